// ===== sv/evr_pkg.sv =====
// shared types and constants for the euler xyz vector rotation unit
// beat structs, register indexes, trig constants and the sequencer state type
// no dependencies
`default_nettype none

package evr_pkg;

   localparam int COMPONENT_BITS = 32;
   localparam int ANGLE_BITS     = 16;
   localparam int CSR_INDEX_BITS = 2;

   // register indexes, also used as axis codes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_Z = 2'd2;

   // angles in 1/64 degree
   localparam int FULL_TURN    = 23040;
   localparam int HALF_TURN    = 11520;
   localparam int THREE_QUARTER_TURN = 17280;
   localparam int QUARTER_TURN = 5760;
   localparam int EIGHTH_TURN  = 2880;

   // pi in q48, split so that the radian conversion needs no wide divide
   localparam logic [63:0] PI48      = 64'h0003_243F_6A88_85A3;
   localparam logic [63:0] THETA_Q   = PI48 / 64'd11520;
   localparam logic [63:0] THETA_R   = PI48 % 64'd11520;
   localparam int          THETA_Q_BITS = 37;
   localparam int          THETA_R_BITS = 14;

   localparam int SERIES_BITS  = 36;
   localparam int SERIES_TERMS = 7;

   typedef struct packed {
      logic signed [COMPONENT_BITS-1:0] dir_x;
      logic signed [COMPONENT_BITS-1:0] dir_y;
      logic signed [COMPONENT_BITS-1:0] dir_z;
   } evr_req_type;

   typedef struct packed {
      logic signed [COMPONENT_BITS-1:0] rot_dir_x;
      logic signed [COMPONENT_BITS-1:0] rot_dir_y;
      logic signed [COMPONENT_BITS-1:0] rot_dir_z;
   } evr_rsp_type;

   typedef struct packed {
      logic                         valid;
      logic [CSR_INDEX_BITS-1:0]    axis;
      logic signed [ANGLE_BITS-1:0] angle;
   } evr_trig_cmd_type;

   // exact floor divide of a 32-bit value by a small constant d:
   // n / d == (n * m) >> (32 + l), m = ceil(2^(32+l) / d), 2^l >= d
   typedef struct packed {
      logic [32:0] m;
      logic [3:0]  l;
   } evr_recip_type;

   // the radian remainder is pre-shifted by 8, leaving a divide by 45
   localparam evr_recip_type THETA_RECIP = '{33'(((65'd1 << 38) + 65'd44) / 65'd45), 4'd6};

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_REDUCE,
      SEQ_THETA_MUL,
      SEQ_THETA_DIV,
      SEQ_THETA_SUM,
      SEQ_SQUARE,
      SEQ_X2,
      SEQ_SIN_MUL,
      SEQ_SIN_DIV,
      SEQ_SIN_ACC,
      SEQ_COS_INIT,
      SEQ_COS_MUL,
      SEQ_COS_DIV,
      SEQ_COS_ACC,
      SEQ_STORE
   } evr_seq_state_type;

   // reciprocal of (2k)(2k+1) for the sine series
   function automatic evr_recip_type sin_recip(input logic [2:0] k);
      evr_recip_type r;
      unique case (k)
         3'd1: r = '{33'(((65'd1 << 35) + 65'd5) / 65'd6), 4'd3};
         3'd2: r = '{33'(((65'd1 << 37) + 65'd19) / 65'd20), 4'd5};
         3'd3: r = '{33'(((65'd1 << 38) + 65'd41) / 65'd42), 4'd6};
         3'd4: r = '{33'(((65'd1 << 39) + 65'd71) / 65'd72), 4'd7};
         3'd5: r = '{33'(((65'd1 << 39) + 65'd109) / 65'd110), 4'd7};
         3'd6: r = '{33'(((65'd1 << 40) + 65'd155) / 65'd156), 4'd8};
         3'd7: r = '{33'(((65'd1 << 40) + 65'd209) / 65'd210), 4'd8};
         default: r = '{33'h1_0000_0000, 4'd0};
      endcase
      return r;
   endfunction

   // reciprocal of (2k-1)(2k) for the cosine series
   function automatic evr_recip_type cos_recip(input logic [2:0] k);
      evr_recip_type r;
      unique case (k)
         3'd2: r = '{33'(((65'd1 << 36) + 65'd11) / 65'd12), 4'd4};
         3'd3: r = '{33'(((65'd1 << 37) + 65'd29) / 65'd30), 4'd5};
         3'd4: r = '{33'(((65'd1 << 38) + 65'd55) / 65'd56), 4'd6};
         3'd5: r = '{33'(((65'd1 << 39) + 65'd89) / 65'd90), 4'd7};
         3'd6: r = '{33'(((65'd1 << 40) + 65'd131) / 65'd132), 4'd8};
         3'd7: r = '{33'(((65'd1 << 40) + 65'd181) / 65'd182), 4'd8};
         default: r = '{33'h1_0000_0000, 4'd0};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/euler_xyz_vector_rotation_unit.sv =====
// top level of the euler xyz vector rotation unit
// eight-stage rotation pipeline fed by the evr_trig sine and cosine sequencer
// depends on evr_pkg and evr_trig
`default_nettype none

// Rotates a Q16.16 direction vector about X, then Y, then Z by three angles held in
// registers 0..2 (signed, 1/64 degree, wrapped modulo 360 degrees). A vector is taken
// on every clock edge where start is high and busy is low, and its rotated vector
// appears on rsp_data after the input, product, sum and saturation registers, marked
// by rsp_strobe for exactly one cycle; the receiver cannot stall, so while busy is low
// one vector per cycle flows in and out in steady state. The pipeline has one multiply
// stage and one add-and-round stage per rotation, plus the input and saturation
// registers. Writing an angle starts the trig sequencer for that axis, which evaluates
// the sine and cosine series one term at a time with a shared multiplier, dividing each
// term by its constant through a reciprocal multiply: busy stays high and csr_ready low
// until the new sine and cosine are stored. Out of reset every angle is zero and the
// block is ready at once. Results saturate to the signed 32-bit range.

module euler_xyz_vector_rotation_unit #(
   parameter int TRIG_FRACTION_BITS = 30
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  evr_pkg::evr_req_type                 req_data,
   output logic                                 rsp_strobe,
   output evr_pkg::evr_rsp_type                 rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [evr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [evr_pkg::ANGLE_BITS-1:0]       csr_data
);
   import evr_pkg::*;

   localparam int W  = COMPONENT_BITS;
   localparam int TW = TRIG_FRACTION_BITS + 2;
   // widths of the unsaturated intermediate components
   localparam int L1 = W + 2;
   localparam int L2 = W + 3;
   localparam int L3 = W + 4;
   // product widths of the three rotations; their sums are one bit wider
   localparam int P1 = W + TW;
   localparam int P2 = L1 + TW;
   localparam int P3 = L2 + TW;

   evr_trig_cmd_type     trig_cmd;
   logic                 trig_idle;
   logic signed [TW-1:0] sin_q [3];
   logic signed [TW-1:0] cos_q [3];

   // angle register writes go straight to the sequencer
   always_comb begin
      csr_ready      = trig_idle;
      busy           = !trig_idle;
      trig_cmd.valid = csr_valid && csr_ready && (csr_index <= CSR_ANGLE_Z);
      trig_cmd.axis  = csr_index;
      trig_cmd.angle = csr_data;
   end

   evr_trig #(
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
   ) u_trig (
      .clock (clock),
      .reset (reset),
      .cmd   (trig_cmd),
      .idle  (trig_idle),
      .sin_q (sin_q),
      .cos_q (cos_q)
   );

   // valid bits, one per stage
   logic [8:1] v_ff, v_in;

   // stage 1: input beat
   logic signed [W-1:0] x0_ff, y0_ff, z0_ff;
   // stage 2: products of the x rotation
   logic signed [P1-1:0] pa1_ff, pb1_ff, pc1_ff, pd1_ff;
   logic signed [W-1:0]  x0d_ff;
   // stage 3: y1 and z1
   logic signed [L1-1:0] y1_ff, z1_ff;
   logic signed [W-1:0]  x1_ff;
   logic signed [L1-1:0] y1_in, z1_in;
   // stage 4: products of the y rotation
   logic signed [P2-1:0] pa2_ff, pb2_ff, pc2_ff, pd2_ff;
   logic signed [L1-1:0] y1d_ff;
   // stage 5: x2 and z2
   logic signed [L2-1:0] x2_ff, z2_ff;
   logic signed [L1-1:0] y1e_ff;
   logic signed [L2-1:0] x2_in, z2_in;
   // stage 6: products of the z rotation
   logic signed [P3-1:0] pa3_ff, pb3_ff, pc3_ff, pd3_ff;
   logic signed [L2-1:0] z2d_ff;
   // stage 7: x3 and y3
   logic signed [L3-1:0] x3_ff, y3_ff;
   logic signed [L2-1:0] z2e_ff;
   logic signed [L3-1:0] x3_in, y3_in;
   // stage 8: saturated result
   evr_rsp_type          rsp_ff, rsp_in;

   logic signed [P1:0] s1a, s1b;
   logic signed [P2:0] s2a, s2b;
   logic signed [P3:0] s3a, s3b;

   function automatic logic signed [W-1:0] sat_l3(input logic signed [L3-1:0] v);
      logic signed [W-1:0] r;
      if (v[L3-1:W-1] == '0 || v[L3-1:W-1] == '1) begin
         r = v[W-1:0];
      end else if (v[L3-1]) begin
         r = {1'b1, {(W-1){1'b0}}};
      end else begin
         r = {1'b0, {(W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [W-1:0] sat_l2(input logic signed [L2-1:0] v);
      return sat_l3(L3'(v));
   endfunction

   // add, round half up and drop the trig fraction
   always_comb begin
      s1a   = (P1+1)'(pa1_ff) + (P1+1)'(pb1_ff) + ((P1+1)'(1) <<< (TRIG_FRACTION_BITS - 1));
      s1b   = (P1+1)'(pc1_ff) + (P1+1)'(pd1_ff) + ((P1+1)'(1) <<< (TRIG_FRACTION_BITS - 1));
      y1_in = s1a[TRIG_FRACTION_BITS +: L1];
      z1_in = s1b[TRIG_FRACTION_BITS +: L1];

      s2a   = (P2+1)'(pa2_ff) + (P2+1)'(pb2_ff) + ((P2+1)'(1) <<< (TRIG_FRACTION_BITS - 1));
      s2b   = (P2+1)'(pc2_ff) + (P2+1)'(pd2_ff) + ((P2+1)'(1) <<< (TRIG_FRACTION_BITS - 1));
      x2_in = s2a[TRIG_FRACTION_BITS +: L2];
      z2_in = s2b[TRIG_FRACTION_BITS +: L2];

      s3a   = (P3+1)'(pa3_ff) + (P3+1)'(pb3_ff) + ((P3+1)'(1) <<< (TRIG_FRACTION_BITS - 1));
      s3b   = (P3+1)'(pc3_ff) + (P3+1)'(pd3_ff) + ((P3+1)'(1) <<< (TRIG_FRACTION_BITS - 1));
      x3_in = s3a[TRIG_FRACTION_BITS +: L3];
      y3_in = s3b[TRIG_FRACTION_BITS +: L3];

      rsp_in.rot_dir_x = sat_l3(x3_ff);
      rsp_in.rot_dir_y = sat_l3(y3_ff);
      rsp_in.rot_dir_z = sat_l2(z2e_ff);
   end

   // no back-pressure, so every stage advances every cycle
   always_comb begin
      v_in[1]   = start && !busy;
      v_in[8:2] = v_ff[7:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      // stage 1
      x0_ff <= req_data.dir_x;
      y0_ff <= req_data.dir_y;
      z0_ff <= req_data.dir_z;
      // stage 2: rotation about x
      pa1_ff <= P1'(y0_ff) * P1'(cos_q[CSR_ANGLE_X]);
      pb1_ff <= P1'(z0_ff) * P1'(-sin_q[CSR_ANGLE_X]);
      pc1_ff <= P1'(y0_ff) * P1'(sin_q[CSR_ANGLE_X]);
      pd1_ff <= P1'(z0_ff) * P1'(cos_q[CSR_ANGLE_X]);
      x0d_ff <= x0_ff;
      // stage 3
      y1_ff <= y1_in;
      z1_ff <= z1_in;
      x1_ff <= x0d_ff;
      // stage 4: rotation about y
      pa2_ff <= P2'(x1_ff) * P2'(cos_q[CSR_ANGLE_Y]);
      pb2_ff <= P2'(z1_ff) * P2'(sin_q[CSR_ANGLE_Y]);
      pc2_ff <= P2'(x1_ff) * P2'(-sin_q[CSR_ANGLE_Y]);
      pd2_ff <= P2'(z1_ff) * P2'(cos_q[CSR_ANGLE_Y]);
      y1d_ff <= y1_ff;
      // stage 5
      x2_ff  <= x2_in;
      z2_ff  <= z2_in;
      y1e_ff <= y1d_ff;
      // stage 6: rotation about z
      pa3_ff <= P3'(x2_ff) * P3'(cos_q[CSR_ANGLE_Z]);
      pb3_ff <= P3'(y1e_ff) * P3'(-sin_q[CSR_ANGLE_Z]);
      pc3_ff <= P3'(x2_ff) * P3'(sin_q[CSR_ANGLE_Z]);
      pd3_ff <= P3'(y1e_ff) * P3'(cos_q[CSR_ANGLE_Z]);
      z2d_ff <= z2_ff;
      // stage 7
      x3_ff  <= x3_in;
      y3_ff  <= y3_in;
      z2e_ff <= z2d_ff;
      // stage 8
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = v_ff[8];
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/evr_trig.sv =====
// sine and cosine sequencer for the three rotation angles
// shared multiplier, constant divides by reciprocal multiply, one series term at a time
// depends on evr_pkg
`default_nettype none

module evr_trig #(
   parameter int TRIG_FRACTION_BITS = 30
) (
   input  logic                           clock,
   input  logic                           reset,
   input  evr_pkg::evr_trig_cmd_type      cmd,
   output logic                           idle,
   output logic signed [TRIG_FRACTION_BITS+1:0] sin_q [3],
   output logic signed [TRIG_FRACTION_BITS+1:0] cos_q [3]
);
   import evr_pkg::*;

   localparam int TW        = TRIG_FRACTION_BITS + 2;
   localparam int RND_SHIFT = 32 - TRIG_FRACTION_BITS;

   evr_seq_state_type state_ff, state_in;

   logic [CSR_INDEX_BITS-1:0]    axis_ff;
   logic signed [ANGLE_BITS-1:0] angle_ff;
   logic [1:0]                   quad_ff;
   logic                         swap_ff;
   logic [11:0]                  rp_ff;
   logic [48:0]                  tnum_ff;
   logic [31:0]                  theta_ff;
   logic [63:0]                  mul_ff;
   logic [31:0]                  x2_ff;
   logic [31:0]                  term_ff;
   logic signed [SERIES_BITS-1:0] sn_ff;
   logic signed [SERIES_BITS-1:0] cs_ff;
   logic [2:0]                   k_ff;
   evr_recip_type                recip_ff;
   logic [31:0]                  quo_ff;
   logic signed [TW-1:0]         sin_ff [3];
   logic signed [TW-1:0]         cos_ff [3];

   // angle fold
   logic signed [17:0] a_ext;
   logic signed [17:0] m_val;
   logic [14:0]        m_u;
   logic [1:0]         quad_c;
   logic [12:0]        r_c;
   logic               swap_c;
   logic [11:0]        rp_c;

   // constant divide
   logic [64:0]        quot_prod;
   logic [31:0]        quot_c;

   // output rounding and quadrant
   logic signed [SERIES_BITS-1:0] rnd_s, rnd_c;
   logic signed [TW-1:0]          s_oct, c_oct, s_base, c_base, s_fin, c_fin;
   logic [48:0]                   theta_sum;
   logic [64:0]                   x2_sum;
   logic [63:0]                   term_prod;
   logic                          store_we;

   always_comb begin
      a_ext = 18'(angle_ff);
      if (a_ext < -18'sd23040) begin
         m_val = a_ext + 18'sd46080;
      end else if (a_ext < 18'sd0) begin
         m_val = a_ext + 18'sd23040;
      end else if (a_ext >= 18'sd23040) begin
         m_val = a_ext - 18'sd23040;
      end else begin
         m_val = a_ext;
      end
      m_u = m_val[14:0];
      priority if (m_u >= 15'(THREE_QUARTER_TURN)) begin
         quad_c = 2'd3;
         r_c    = 13'(m_u - 15'(THREE_QUARTER_TURN));
      end else if (m_u >= 15'(HALF_TURN)) begin
         quad_c = 2'd2;
         r_c    = 13'(m_u - 15'(HALF_TURN));
      end else if (m_u >= 15'(QUARTER_TURN)) begin
         quad_c = 2'd1;
         r_c    = 13'(m_u - 15'(QUARTER_TURN));
      end else begin
         quad_c = 2'd0;
         r_c    = m_u[12:0];
      end
      swap_c = r_c > 13'(EIGHTH_TURN);
      rp_c   = swap_c ? 12'(13'(QUARTER_TURN) - r_c) : r_c[11:0];
   end

   // floor divide by the current constant in one multiply
   always_comb begin
      quot_prod = 65'(quo_ff) * 65'(recip_ff.m);
      quot_c    = 32'(quot_prod >> (7'd32 + 7'(recip_ff.l)));
   end

   always_comb begin
      theta_sum = tnum_ff + 49'(quo_ff) + 49'h8000;
      x2_sum    = 65'(mul_ff) + 65'h8000_0000;
      term_prod = 64'(term_ff) * 64'(x2_ff);
   end

   always_comb begin
      rnd_s = sn_ff + (SERIES_BITS'(1) <<< (31 - TRIG_FRACTION_BITS));
      rnd_c = cs_ff + (SERIES_BITS'(1) <<< (31 - TRIG_FRACTION_BITS));
      s_oct = rnd_s[RND_SHIFT +: TW];
      c_oct = rnd_c[RND_SHIFT +: TW];
      s_base = swap_ff ? c_oct : s_oct;
      c_base = swap_ff ? s_oct : c_oct;
      unique case (quad_ff)
         2'd0: begin s_fin = s_base;  c_fin = c_base;  end
         2'd1: begin s_fin = c_base;  c_fin = -s_base; end
         2'd2: begin s_fin = -s_base; c_fin = -c_base; end
         2'd3: begin s_fin = -c_base; c_fin = s_base;  end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE:      if (cmd.valid) state_in = SEQ_REDUCE;
         SEQ_REDUCE:    state_in = SEQ_THETA_MUL;
         SEQ_THETA_MUL: state_in = SEQ_THETA_DIV;
         SEQ_THETA_DIV: state_in = SEQ_THETA_SUM;
         SEQ_THETA_SUM: state_in = SEQ_SQUARE;
         SEQ_SQUARE:    state_in = SEQ_X2;
         SEQ_X2:        state_in = SEQ_SIN_MUL;
         SEQ_SIN_MUL:   state_in = SEQ_SIN_DIV;
         SEQ_SIN_DIV:   state_in = SEQ_SIN_ACC;
         SEQ_SIN_ACC:   state_in = (k_ff == 3'(SERIES_TERMS)) ? SEQ_COS_INIT : SEQ_SIN_MUL;
         SEQ_COS_INIT:  state_in = SEQ_COS_MUL;
         SEQ_COS_MUL:   state_in = SEQ_COS_DIV;
         SEQ_COS_DIV:   state_in = SEQ_COS_ACC;
         SEQ_COS_ACC:   state_in = (k_ff == 3'(SERIES_TERMS)) ? SEQ_STORE : SEQ_COS_MUL;
         SEQ_STORE:     state_in = SEQ_IDLE;
         default:       state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      idle     = state_ff == SEQ_IDLE;
      store_we = state_ff == SEQ_STORE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            sin_ff[i] <= '0;
            cos_ff[i] <= TW'(1) <<< TRIG_FRACTION_BITS;
         end
      end else if (store_we) begin
         sin_ff[axis_ff] <= s_fin;
         cos_ff[axis_ff] <= c_fin;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         SEQ_IDLE: begin
            axis_ff  <= cmd.axis;
            angle_ff <= cmd.angle;
         end
         SEQ_REDUCE: begin
            quad_ff <= quad_c;
            swap_ff <= swap_c;
            rp_ff   <= rp_c;
         end
         SEQ_THETA_MUL: begin
            tnum_ff  <= 49'(rp_ff) * 49'(THETA_Q[THETA_Q_BITS-1:0]);
            // 11520 is 256 times 45
            quo_ff   <= 32'((26'(rp_ff) * 26'(THETA_R[THETA_R_BITS-1:0])) >> 8);
            recip_ff <= THETA_RECIP;
         end
         SEQ_THETA_DIV, SEQ_SIN_DIV, SEQ_COS_DIV: begin
            quo_ff <= quot_c;
         end
         SEQ_THETA_SUM: begin
            theta_ff <= theta_sum[47:16];
         end
         SEQ_SQUARE: begin
            mul_ff <= 64'(theta_ff) * 64'(theta_ff);
         end
         SEQ_X2: begin
            x2_ff   <= x2_sum[63:32];
            term_ff <= theta_ff;
            sn_ff   <= SERIES_BITS'(theta_ff);
            k_ff    <= 3'd1;
         end
         SEQ_SIN_MUL: begin
            quo_ff   <= term_prod[63:32];
            recip_ff <= sin_recip(k_ff);
         end
         SEQ_SIN_ACC: begin
            term_ff <= quo_ff;
            sn_ff   <= k_ff[0] ? sn_ff - SERIES_BITS'(quo_ff) : sn_ff + SERIES_BITS'(quo_ff);
            k_ff    <= k_ff + 3'd1;
         end
         SEQ_COS_INIT: begin
            term_ff <= {1'b0, x2_ff[31:1]};
            cs_ff   <= (SERIES_BITS'(1) <<< 32) - SERIES_BITS'(x2_ff[31:1]);
            k_ff    <= 3'd2;
         end
         SEQ_COS_MUL: begin
            quo_ff   <= term_prod[63:32];
            recip_ff <= cos_recip(k_ff);
         end
         SEQ_COS_ACC: begin
            term_ff <= quo_ff;
            cs_ff   <= k_ff[0] ? cs_ff - SERIES_BITS'(quo_ff) : cs_ff + SERIES_BITS'(quo_ff);
            k_ff    <= k_ff + 3'd1;
         end
         SEQ_STORE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sin_q[i] = sin_ff[i];
         cos_q[i] = cos_ff[i];
      end
   end

endmodule

`default_nettype wire

// ===== bench/euler_xyz_vector_rotation_unit_test.sv =====
// self-checking bench for the euler xyz vector rotation unit
// holds a bit-exact rotation predictor in a scoreboard class, drives the command and
// register ports, checks rsp_data; depends on evr_pkg and euler_xyz_vector_rotation_unit
module euler_xyz_vector_rotation_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import evr_pkg::*;

   localparam int TF = 30;              // trig fraction bits of the instance
   localparam int PIPE_DEPTH = 8;       // stage count of the result pipeline
   localparam int SETTLE = 16;          // slack before a register write

   typedef struct {
      logic signed [63:0] s;
      logic signed [63:0] c;
   } sincos_type;

   // scoreboard: keeps its own copy of the angles and the queue of expected rotations
   class rotation_board;
      int signed ang[3];
      evr_rsp_type rotations_due[$];
      int errors;

      function new();
         ang = '{0, 0, 0};
         errors = 0;
      endfunction

      function void set_angle(logic [CSR_INDEX_BITS-1:0] idx, logic [ANGLE_BITS-1:0] v);
         // index three has no register behind it
         if (idx == CSR_ANGLE_X) ang[0] = $signed(v);
         else if (idx == CSR_ANGLE_Y) ang[1] = $signed(v);
         else if (idx == CSR_ANGLE_Z) ang[2] = $signed(v);
      endfunction

      // power series on one octant, r in [0, eighth turn]
      function sincos_type octant_series(logic [63:0] r);
         logic [63:0] theta, x2, term;
         logic signed [63:0] sn, cs;
         sincos_type t;
         theta = ((r * PI48) / 64'd11520 + 64'h8000) >> 16;
         x2 = (theta * theta + 64'h8000_0000) >> 32;
         term = theta;
         sn = theta;
         cs = 64'sd1 <<< 32;
         for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = ((term * x2) >> 32) / 64'((2 * k) * (2 * k + 1));
            if (k & 1) sn = sn - $signed(term);
            else sn = sn + $signed(term);
         end
         term = x2 / 64'd2;
         cs = cs - $signed(term);
         for (int k = 2; k <= SERIES_TERMS; k++) begin
            term = ((term * x2) >> 32) / 64'((2 * k - 1) * (2 * k));
            if (k & 1) cs = cs - $signed(term);
            else cs = cs + $signed(term);
         end
         t.s = (sn + (64'sd1 <<< (31 - TF))) >>> (32 - TF);
         t.c = (cs + (64'sd1 <<< (31 - TF))) >>> (32 - TF);
         return t;
      endfunction

      // wrap to one turn, fold the octant, then fix signs by quadrant
      function sincos_type angle_sincos(int signed a);
         int signed m, quad, r;
         sincos_type b, o;
         logic signed [63:0] s, c;
         m = a % FULL_TURN;
         if (m < 0) m += FULL_TURN;
         quad = m / QUARTER_TURN;
         r = m % QUARTER_TURN;
         if (r > EIGHTH_TURN) begin
            b = octant_series(64'(QUARTER_TURN - r));
            s = b.c;
            c = b.s;
         end else begin
            b = octant_series(64'(r));
            s = b.s;
            c = b.c;
         end
         case (quad)
            0: begin o.s = s; o.c = c; end
            1: begin o.s = c; o.c = -s; end
            2: begin o.s = -s; o.c = -c; end
            default: begin o.s = -c; o.c = s; end
         endcase
         return o;
      endfunction

      // exact a*c + b*d, rounded half up by the trig scale
      function logic signed [63:0] mac_round(logic signed [63:0] a, logic signed [63:0] c,
                                             logic signed [63:0] b, logic signed [63:0] d);
         logic signed [127:0] wa, wb, wc, wd, sum;
         wa = a; wb = b; wc = c; wd = d;
         sum = wa * wc + wb * wd + (128'sd1 <<< (TF - 1));
         return sum[TF+63:TF];
      endfunction

      function logic signed [31:0] clamp32(logic signed [63:0] v);
         if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'h8000_0000;
         return v[31:0];
      endfunction

      function void note_vector(evr_req_type v);
         sincos_type tx, ty, tz;
         logic signed [63:0] x, y, z, y1, z1, x2, z2, x3, y3;
         evr_rsp_type e;
         tx = angle_sincos(ang[0]);
         ty = angle_sincos(ang[1]);
         tz = angle_sincos(ang[2]);
         x = v.dir_x; y = v.dir_y; z = v.dir_z;
         y1 = mac_round(y, tx.c, z, -tx.s);
         z1 = mac_round(y, tx.s, z, tx.c);
         x2 = mac_round(x, ty.c, z1, ty.s);
         z2 = mac_round(x, -ty.s, z1, ty.c);
         x3 = mac_round(x2, tz.c, y1, -tz.s);
         y3 = mac_round(x2, tz.s, y1, tz.c);
         e.rot_dir_x = clamp32(x3);
         e.rot_dir_y = clamp32(y3);
         e.rot_dir_z = clamp32(z2);
         rotations_due.push_back(e);
      endfunction

      function void check_rotation(evr_rsp_type got);
         evr_rsp_type e;
         if (rotations_due.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                     got.rot_dir_x, got.rot_dir_y, got.rot_dir_z);
            errors++;
            return;
         end
         e = rotations_due.pop_front();
         if (got.rot_dir_x !== e.rot_dir_x) begin
            $display("%0t: rot_dir_x expected %h actual %h", $time, e.rot_dir_x, got.rot_dir_x);
            errors++;
         end
         if (got.rot_dir_y !== e.rot_dir_y) begin
            $display("%0t: rot_dir_y expected %h actual %h", $time, e.rot_dir_y, got.rot_dir_y);
            errors++;
         end
         if (got.rot_dir_z !== e.rot_dir_z) begin
            $display("%0t: rot_dir_z expected %h actual %h", $time, e.rot_dir_z, got.rot_dir_z);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   evr_req_type req_data = '0;
   logic rsp_strobe;
   evr_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ANGLE_BITS-1:0] csr_data = '0;

   rotation_board board = new();

   euler_xyz_vector_rotation_unit #(.TRIG_FRACTION_BITS(TF)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // results cannot be held off, so every strobed cycle is one beat
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_rotation(rsp_data);
   end

   // generous ceiling, far above the slowest correct run
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   // one command beat; start stays high afterwards unless the next beat idles first
   task automatic send_vector(evr_req_type v, int idle_pct);
      bit taken;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data = v;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         if (!busy) begin
            taken = 1;
            board.note_vector(v);
         end
      end
   endtask

   // stop sending and let every expected rotation come back
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (board.rotations_due.size() != 0) @(negedge clock);
   endtask

   // register write while idle; the write itself waits on csr_ready
   task automatic write_angle(logic [CSR_INDEX_BITS-1:0] idx, logic [ANGLE_BITS-1:0] v);
      drain();
      repeat (SETTLE) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = v;
      do @(posedge clock); while (!csr_ready);
      board.set_angle(idx, v);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_angles(int signed ax, int signed ay, int signed az);
      write_angle(CSR_ANGLE_X, ANGLE_BITS'(ax));
      write_angle(CSR_ANGLE_Y, ANGLE_BITS'(ay));
      write_angle(CSR_ANGLE_Z, ANGLE_BITS'(az));
   endtask

   function automatic int signed pick_angle();
      int signed corners[12] = '{0, 23040, -23040, 32767, -32768, 2880, 2881,
                                 5760, 11520, 17280, -5760, 2879};
      case ($urandom_range(3))
         0: return $signed(16'($urandom));
         1: return int'($urandom_range(46080)) - 23040;
         2: return corners[$urandom_range(11)];
         default: return int'($urandom_range(200)) - 100;
      endcase
   endfunction

   function automatic logic [31:0] pick_component();
      case ($urandom_range(4))
         0, 1: return $urandom;
         2: return 32'(int'($urandom_range(131072)) - 65536);   // near unit length
         3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed(20'($urandom)));
      endcase
   endfunction

   task automatic directed_vectors();
      evr_req_type v;
      v = '0;                                         send_vector(v, 0);
      v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; send_vector(v, 0);
      v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; send_vector(v, 0);
      v = '{32'h0001_0000, 32'h0, 32'h0};             send_vector(v, 0);
      v = '{32'h0, 32'hFFFF_0000, 32'h0001_0000};     send_vector(v, 0);
      v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF}; send_vector(v, 0);
   endtask

   initial begin
      evr_req_type v;
      int idle_pct, phase_len;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part: zero angles out of reset, wrap limits, octant fold and quadrants
      directed_vectors();
      set_angles(23040, -23040, -32768);
      directed_vectors();
      set_angles(32767, 2880, 2881);
      write_angle(2'd3, 16'h1234);                    // unmapped index must be ignored
      directed_vectors();
      set_angles(5760, 11520, 17280);
      directed_vectors();

      // random part: three sender idling regimes over nine angle settings
      for (int phase = 0; phase < 9; phase++) begin
         idle_pct = (phase < 3) ? 27 : (phase < 6) ? 66 : 0;
         set_angles(pick_angle(), pick_angle(), pick_angle());
         if ($urandom_range(1)) write_angle(2'd3, 16'($urandom));
         phase_len = 200 + $urandom_range(20);
         for (int n = 0; n < phase_len; n++) begin
            if (n == phase_len / 2) drain();          // hold off until every beat is back
            v.dir_x = pick_component();
            v.dir_y = pick_component();
            v.dir_z = pick_component();
            send_vector(v, idle_pct);
         end
      end

      drain();
      repeat (PIPE_DEPTH + SETTLE) @(negedge clock);
      if (board.errors == 0 && board.rotations_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
sv/evr_pkg.sv
sv/evr_trig.sv
sv/euler_xyz_vector_rotation_unit.sv
bench/euler_xyz_vector_rotation_unit_test.sv
